// ===== design/pott_pkg.sv =====
`default_nettype none
package pott_pkg;
  localparam int DiffW = 33;
  localparam int ProdW = 66;
  localparam int CrossW = 67;
  localparam int LimbW = 34;
  localparam int HighW = CrossW - LimbW;
  localparam int PartW = 2 * LimbW;
  localparam int Prod2W = 134;
  localparam int DotW = 136;
  localparam int MagW = 101;
  localparam int RemW = 210;
  localparam int RootW = 32;
  localparam int NProd = 15;

  localparam logic [1:0] POS_OUTSIDE = 2'd0;
  localparam logic [1:0] POS_ABOVE = 2'd1;
  localparam logic [1:0] POS_BELOW = 2'd2;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [HighW-1:0] high_t;
  typedef logic signed [LimbW:0] low_t;
  typedef logic signed [PartW-1:0] spart_t;
  typedef logic [PartW-1:0] part_t;
  typedef logic [LimbW-1:0] limb_t;
  typedef logic signed [Prod2W-1:0] prod2_t;
  typedef logic signed [DotW-1:0] dot_t;
  typedef logic [RemW-1:0] rem_t;
endpackage
`default_nettype wire

// ===== design/point_over_triangle_test_unit.sv =====
// channel | signals                                   | handshake
// --------+-------------------------------------------+--------------------------
// input   | vert1_*..vert3_*, query_x/y/z (Q16.16)    | start & !busy
// result  | position, plane_offset (Q16.16)           | done, one cycle
//
// Fully pipelined: one word per cycle; done rises when the word leaves the output
// stage, and the result is taken at the clock edge while done is high.
// Nine stages form the differences, cross and dot products (partial products of
// 34-bit limbs, then sums) and |D|^2; 32 restoring root stages give |D|/sqrt(N.N)
// one bit each; one output stage saturates. busy is always low.
// Reset (rst, synchronous) clears only the valid bits; the receiver cannot stall.
`default_nettype none
module point_over_triangle_test_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire signed [31:0]  vert1_x,
  input  wire signed [31:0]  vert1_y,
  input  wire signed [31:0]  vert1_z,
  input  wire signed [31:0]  vert2_x,
  input  wire signed [31:0]  vert2_y,
  input  wire signed [31:0]  vert2_z,
  input  wire signed [31:0]  vert3_x,
  input  wire signed [31:0]  vert3_y,
  input  wire signed [31:0]  vert3_z,
  input  wire signed [31:0]  query_x,
  input  wire signed [31:0]  query_y,
  input  wire signed [31:0]  query_z,
  output logic               done,
  output logic [1:0]         position,
  output logic signed [31:0] plane_offset
);
  localparam int Steps = pott_pkg::RootW;
  localparam int NP = pott_pkg::NProd;
  localparam int LW = pott_pkg::LimbW;

  assign busy = 1'b0;

  // stage 1: edge and point differences
  logic v1;
  pott_pkg::diff_t ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz, rx, ry, rz;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    ax <= pott_pkg::diff_t'(vert2_x) - pott_pkg::diff_t'(vert1_x);
    ay <= pott_pkg::diff_t'(vert2_y) - pott_pkg::diff_t'(vert1_y);
    az <= pott_pkg::diff_t'(vert2_z) - pott_pkg::diff_t'(vert1_z);
    bx <= pott_pkg::diff_t'(vert3_x) - pott_pkg::diff_t'(vert1_x);
    by <= pott_pkg::diff_t'(vert3_y) - pott_pkg::diff_t'(vert1_y);
    bz <= pott_pkg::diff_t'(vert3_z) - pott_pkg::diff_t'(vert1_z);
    cx <= pott_pkg::diff_t'(vert3_x) - pott_pkg::diff_t'(vert2_x);
    cy <= pott_pkg::diff_t'(vert3_y) - pott_pkg::diff_t'(vert2_y);
    cz <= pott_pkg::diff_t'(vert3_z) - pott_pkg::diff_t'(vert2_z);
    qx <= pott_pkg::diff_t'(query_x) - pott_pkg::diff_t'(vert1_x);
    qy <= pott_pkg::diff_t'(query_y) - pott_pkg::diff_t'(vert1_y);
    qz <= pott_pkg::diff_t'(query_z) - pott_pkg::diff_t'(vert1_z);
    rx <= pott_pkg::diff_t'(query_x) - pott_pkg::diff_t'(vert2_x);
    ry <= pott_pkg::diff_t'(query_y) - pott_pkg::diff_t'(vert2_y);
    rz <= pott_pkg::diff_t'(query_z) - pott_pkg::diff_t'(vert2_z);
  end

  // stage 2: cross product terms
  logic v2;
  pott_pkg::prod_t pn [0:5];
  pott_pkg::prod_t p1 [0:5];
  pott_pkg::prod_t p2 [0:5];
  pott_pkg::prod_t p3 [0:5];
  pott_pkg::diff_t q2x, q2y, q2z;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    pn[0] <= ay * bz; pn[1] <= az * by;
    pn[2] <= az * bx; pn[3] <= ax * bz;
    pn[4] <= ax * by; pn[5] <= ay * bx;
    p1[0] <= ay * qz; p1[1] <= az * qy;
    p1[2] <= az * qx; p1[3] <= ax * qz;
    p1[4] <= ax * qy; p1[5] <= ay * qx;
    p2[0] <= qy * bz; p2[1] <= qz * by;
    p2[2] <= qz * bx; p2[3] <= qx * bz;
    p2[4] <= qx * by; p2[5] <= qy * bx;
    p3[0] <= cy * rz; p3[1] <= cz * ry;
    p3[2] <= cz * rx; p3[3] <= cx * rz;
    p3[4] <= cx * ry; p3[5] <= cy * rx;
    q2x <= qx; q2y <= qy; q2z <= qz;
  end

  // stage 3: cross products
  logic v3;
  pott_pkg::cross_t nx, ny, nz, e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z;
  pott_pkg::diff_t q3x, q3y, q3z;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    nx <= pott_pkg::cross_t'(pn[0]) - pott_pkg::cross_t'(pn[1]);
    ny <= pott_pkg::cross_t'(pn[2]) - pott_pkg::cross_t'(pn[3]);
    nz <= pott_pkg::cross_t'(pn[4]) - pott_pkg::cross_t'(pn[5]);
    e1x <= pott_pkg::cross_t'(p1[0]) - pott_pkg::cross_t'(p1[1]);
    e1y <= pott_pkg::cross_t'(p1[2]) - pott_pkg::cross_t'(p1[3]);
    e1z <= pott_pkg::cross_t'(p1[4]) - pott_pkg::cross_t'(p1[5]);
    e2x <= pott_pkg::cross_t'(p2[0]) - pott_pkg::cross_t'(p2[1]);
    e2y <= pott_pkg::cross_t'(p2[2]) - pott_pkg::cross_t'(p2[3]);
    e2z <= pott_pkg::cross_t'(p2[4]) - pott_pkg::cross_t'(p2[5]);
    e3x <= pott_pkg::cross_t'(p3[0]) - pott_pkg::cross_t'(p3[1]);
    e3y <= pott_pkg::cross_t'(p3[2]) - pott_pkg::cross_t'(p3[3]);
    e3z <= pott_pkg::cross_t'(p3[4]) - pott_pkg::cross_t'(p3[5]);
    q3x <= q2x; q3y <= q2y; q3z <= q2z;
  end

  // stages 4 and 5: dot product terms as split partial products, then summed
  logic v4, v5, in4, in5;
  pott_pkg::cross_t ma [0:NP-1];
  pott_pkg::cross_t mb [0:NP-1];
  pott_pkg::spart_t phh [0:NP-1];
  pott_pkg::spart_t phl [0:NP-1];
  pott_pkg::spart_t plh [0:NP-1];
  pott_pkg::part_t  pll [0:NP-1];
  pott_pkg::prod2_t pr  [0:NP-1];
  always_comb begin
    ma[0] = e1x;  mb[0] = nx;  ma[1] = e1y;  mb[1] = ny;  ma[2] = e1z;  mb[2] = nz;
    ma[3] = e2x;  mb[3] = nx;  ma[4] = e2y;  mb[4] = ny;  ma[5] = e2z;  mb[5] = nz;
    ma[6] = e3x;  mb[6] = nx;  ma[7] = e3y;  mb[7] = ny;  ma[8] = e3z;  mb[8] = nz;
    ma[9] = nx;   mb[9] = nx;  ma[10] = ny;  mb[10] = ny; ma[11] = nz;  mb[11] = nz;
    ma[12] = pott_pkg::cross_t'(q3x); mb[12] = nx;
    ma[13] = pott_pkg::cross_t'(q3y); mb[13] = ny;
    ma[14] = pott_pkg::cross_t'(q3z); mb[14] = nz;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= v3;
      v5 <= v4;
    end
    in4 <= 1'b0;
    in5 <= in4;
  end

  for (genvar j = 0; j < NP; j++) begin : g_mul
    pott_pkg::high_t ah, bh;
    pott_pkg::low_t  al, bl;
    always_comb begin
      ah = ma[j][pott_pkg::CrossW-1:LW];
      bh = mb[j][pott_pkg::CrossW-1:LW];
      al = {1'b0, ma[j][LW-1:0]};
      bl = {1'b0, mb[j][LW-1:0]};
    end
    always_ff @(posedge clk) begin
      phh[j] <= ah * bh;
      phl[j] <= ah * bl;
      plh[j] <= al * bh;
      pll[j] <= al[LW-1:0] * bl[LW-1:0];
      pr[j] <= (pott_pkg::prod2_t'(phh[j]) <<< (2 * LW))
             + ((pott_pkg::prod2_t'(phl[j]) + pott_pkg::prod2_t'(plh[j])) <<< LW)
             + pott_pkg::prod2_t'(pll[j]);
    end
  end

  // stage 6: edge signs, plane distance numerator, normal length squared
  logic v6, in6;
  pott_pkg::dot_t s1, s2, s3, d6, m6;
  always_comb begin
    s1 = pott_pkg::dot_t'(pr[0]) + pott_pkg::dot_t'(pr[1]) + pott_pkg::dot_t'(pr[2]);
    s2 = pott_pkg::dot_t'(pr[3]) + pott_pkg::dot_t'(pr[4]) + pott_pkg::dot_t'(pr[5]);
    s3 = pott_pkg::dot_t'(pr[6]) + pott_pkg::dot_t'(pr[7]) + pott_pkg::dot_t'(pr[8]);
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    in6 <= (s1 > 0) && (s2 > 0) && (s3 > 0);
    m6 <= pott_pkg::dot_t'(pr[9]) + pott_pkg::dot_t'(pr[10]) + pott_pkg::dot_t'(pr[11]);
    d6 <= pott_pkg::dot_t'(pr[12]) + pott_pkg::dot_t'(pr[13]) + pott_pkg::dot_t'(pr[14]);
  end

  // stage 7: |D|
  logic v7, in7, neg7;
  logic [pott_pkg::MagW-1:0] mag7;
  pott_pkg::rem_t m7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    in7 <= in6;
    neg7 <= d6[pott_pkg::DotW-1];
    mag7 <= d6[pott_pkg::DotW-1] ? pott_pkg::MagW'(-d6) : pott_pkg::MagW'(d6);
    m7 <= pott_pkg::rem_t'(m6[pott_pkg::DotW-2:0]);
  end

  // stages 8 and 9: |D| squared from 34-bit limbs
  logic v8, in8, neg8, v9, in9, neg9;
  pott_pkg::limb_t l0, l1, l2;
  pott_pkg::part_t sq [0:5];
  pott_pkg::rem_t m8, m9, d2;
  always_comb begin
    l0 = mag7[LW-1:0];
    l1 = mag7[2*LW-1:LW];
    l2 = {1'b0, mag7[pott_pkg::MagW-1:2*LW]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v8 <= v7;
      v9 <= v8;
    end
    in8 <= in7; neg8 <= neg7; m8 <= m7;
    sq[0] <= l0 * l0; sq[1] <= l0 * l1; sq[2] <= l0 * l2;
    sq[3] <= l1 * l1; sq[4] <= l1 * l2; sq[5] <= l2 * l2;
    in9 <= in8; neg9 <= neg8; m9 <= m8;
    d2 <= pott_pkg::rem_t'(sq[0])
        + (pott_pkg::rem_t'(sq[1]) << (LW + 1))
        + (pott_pkg::rem_t'(sq[2]) << (2 * LW + 1))
        + (pott_pkg::rem_t'(sq[3]) << (2 * LW))
        + (pott_pkg::rem_t'(sq[4]) << (3 * LW + 1))
        + (pott_pkg::rem_t'(sq[5]) << (4 * LW));
  end

  // root search: largest t with t*t*M <= D*D, one bit per stage
  logic               sv  [0:Steps];
  logic               sin [0:Steps];
  logic               sng [0:Steps];
  pott_pkg::rem_t     srm [0:Steps];
  pott_pkg::rem_t     stm [0:Steps];
  pott_pkg::rem_t     sm  [0:Steps];
  logic [Steps-1:0]   st  [0:Steps];

  always_comb begin
    sv[0] = v9; sin[0] = in9; sng[0] = neg9;
    srm[0] = d2; stm[0] = '0; sm[0] = m9; st[0] = '0;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_root
    localparam int B = Steps - 1 - k;
    pott_pkg::rem_t delta;
    always_comb begin
      delta = (stm[k] << (B + 1)) + (sm[k] << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      sin[k+1] <= sin[k];
      sng[k+1] <= sng[k];
      sm[k+1] <= sm[k];
      if (delta <= srm[k]) begin
        srm[k+1] <= srm[k] - delta;
        stm[k+1] <= stm[k] + (sm[k] << B);
        st[k+1] <= st[k] | (Steps'(1) << B);
      end else begin
        srm[k+1] <= srm[k];
        stm[k+1] <= stm[k];
        st[k+1] <= st[k];
      end
    end
  end

  // output stage: saturate and sign
  logic [Steps-1:0] tq;
  assign tq = st[Steps];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sv[Steps];
    if (!sin[Steps]) begin
      position <= pott_pkg::POS_OUTSIDE;
      plane_offset <= '0;
    end else if (sng[Steps]) begin
      position <= pott_pkg::POS_BELOW;
      plane_offset <= (tq > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(tq);
    end else begin
      position <= pott_pkg::POS_ABOVE;
      plane_offset <= tq[31] ? 32'sh7fff_ffff : $signed(tq);
    end
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(sv[Steps]))
    else $error("result without word");
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    done && position == pott_pkg::POS_OUTSIDE |-> plane_offset == 32'sd0)
    else $error("outside with offset");
  a_sign: assert property (@(posedge clk) disable iff (rst)
    done && position == pott_pkg::POS_ABOVE |-> !plane_offset[31])
    else $error("above with negative offset");
endmodule
`default_nettype wire

// ===== test/pott_checker.sv =====
`timescale 1ns / 1ps
module pott_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               busy,
  input  wire signed [31:0] vert1_x,
  input  wire signed [31:0] vert1_y,
  input  wire signed [31:0] vert1_z,
  input  wire signed [31:0] vert2_x,
  input  wire signed [31:0] vert2_y,
  input  wire signed [31:0] vert2_z,
  input  wire signed [31:0] vert3_x,
  input  wire signed [31:0] vert3_y,
  input  wire signed [31:0] vert3_z,
  input  wire signed [31:0] query_x,
  input  wire signed [31:0] query_y,
  input  wire signed [31:0] query_z,
  input  wire               done,
  input  wire [1:0]         position,
  input  wire signed [31:0] plane_offset,
  output int                mismatches,
  output int                pending
);
  typedef logic signed [255:0] wide_t;
  typedef struct {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec_t;
  typedef struct {
    logic [1:0]  pos;
    logic [31:0] offset;
  } verdict_t;

  verdict_t verdicts[$];

  function automatic vec_t mk(input logic signed [31:0] x, y, z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic vec_t vminus(input vec_t a, b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vcross(input vec_t a, b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(input vec_t a, b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic verdict_t locate_point(input vec_t v1, v2, v3, p);
    vec_t ea, eb, ec, q, r, nrm;
    wide_t s1, s2, s3, d, m, mag, d2, cw;
    logic [63:0] t, cand;
    verdict_t res;
    ea = vminus(v2, v1);
    eb = vminus(v3, v1);
    ec = vminus(v3, v2);
    q = vminus(p, v1);
    r = vminus(p, v2);
    nrm = vcross(ea, eb);
    s1 = vdot(vcross(ea, q), nrm);
    s2 = vdot(vcross(q, eb), nrm);
    s3 = vdot(vcross(ec, r), nrm);
    res.pos = pott_pkg::POS_OUTSIDE;
    res.offset = '0;
    if (s1 > 0 && s2 > 0 && s3 > 0) begin
      d = vdot(q, nrm);
      m = vdot(nrm, nrm);
      mag = (d < 0) ? -d : d;
      d2 = mag * mag;
      t = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = t | (64'd1 << b);
        cw = {192'd0, cand};
        if (cw * cw * m <= d2) t = cand;
      end
      if (d < 0) begin
        if (t > 64'h8000_0000) t = 64'h8000_0000;
        res.pos = pott_pkg::POS_BELOW;
        res.offset = 32'd0 - t[31:0];
      end else begin
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
        res.pos = pott_pkg::POS_ABOVE;
        res.offset = t[31:0];
      end
    end
    return res;
  endfunction

  assign pending = verdicts.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if (start && !busy)
        verdicts.push_back(locate_point(mk(vert1_x, vert1_y, vert1_z),
                                        mk(vert2_x, vert2_y, vert2_z),
                                        mk(vert3_x, vert3_y, vert3_z),
                                        mk(query_x, query_y, query_z)));
      if (done) begin
        if (verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: position %0d offset %h", position, plane_offset);
        end else begin
          want = verdicts.pop_front();
          if (want.pos !== position || want.offset !== plane_offset) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: position exp %0d got %0d, offset exp %h got %h",
                       want.pos, position, want.offset, plane_offset);
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_point_over_triangle_test_unit.sv =====
`timescale 1ns / 1ps
module tb_point_over_triangle_test_unit;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] position;
  logic signed [31:0] plane_offset;
  logic signed [31:0] crd[12];
  int mismatches, pending;
  int idle_pct;

  always #5 clk = ~clk;

  point_over_triangle_test_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vert1_x(crd[0]), .vert1_y(crd[1]), .vert1_z(crd[2]),
    .vert2_x(crd[3]), .vert2_y(crd[4]), .vert2_z(crd[5]),
    .vert3_x(crd[6]), .vert3_y(crd[7]), .vert3_z(crd[8]),
    .query_x(crd[9]), .query_y(crd[10]), .query_z(crd[11]),
    .done(done), .position(position), .plane_offset(plane_offset)
  );

  pott_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vert1_x(crd[0]), .vert1_y(crd[1]), .vert1_z(crd[2]),
    .vert2_x(crd[3]), .vert2_y(crd[4]), .vert2_z(crd[5]),
    .vert3_x(crd[6]), .vert3_y(crd[7]), .vert3_z(crd[8]),
    .query_x(crd[9]), .query_y(crd[10]), .query_z(crd[11]),
    .done(done), .position(position), .plane_offset(plane_offset),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    for (int i = 0; i < 12; i++) crd[i] = '0;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic signed [31:0] w[12]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 12; i++) crd[i] <= w[i];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2, p0, p1, p2);
    logic signed [31:0] w[12];
    w = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, p0, p1, p2};
    send_word(w);
  endtask

  task automatic send_random();
    logic signed [31:0] w[12];
    longint v[9], wa, wb, wc, lim, s;
    int kind;
    kind = $urandom_range(99);
    if (kind < 20) begin
      for (int i = 0; i < 12; i++) w[i] = $urandom;
    end else begin
      case ($urandom_range(3))
        0: lim = 64'd1 << 8;
        1: lim = 64'd1 << 16;
        2: lim = 64'd1 << 24;
        default: lim = 64'd1 << 29;
      endcase
      for (int i = 0; i < 9; i++) v[i] = $signed($urandom_range(32'(2 * lim))) - lim;
      for (int i = 0; i < 9; i++) w[i] = 32'(v[i]);
      wa = $urandom_range(1, 1000);
      wb = $urandom_range(1, 1000);
      wc = $urandom_range(1, 1000);
      s = wa + wb + wc;
      for (int k = 0; k < 3; k++)
        w[9 + k] = 32'((wa * v[k] + wb * v[3 + k] + wc * v[6 + k]) / s
                       + $signed($urandom_range(32'(2 * lim))) - lim);
      if (kind < 30)
        for (int k = 0; k < 3; k++) w[9 + k] = w[9 + k] + $signed($urandom_range(6)) - 3;
    end
    send_word(w);
  endtask

  initial begin
    int mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tri(0, 0, 0, 65536, 65536, 0, 131072, 131072, 0, 100, 0, 5);
    send_tri(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn);
    send_tri(mn, mn, mn, mn, mn, mn, mx, mx, mx, 0, 0, 0);
    send_tri(0, 0, mn, 65536, 0, mn, 0, 65536, mn, 100, 100, mx);
    send_tri(0, 0, mn, 0, 65536, mn, 65536, 0, mn, 100, 100, mx);
    send_tri(0, 0, mx, 65536, 0, mx, 0, 65536, mx, 100, 100, mn);
    send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 100, 100, 500);
    send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 100, 100, -500);
    send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 100, 100, 0);
    send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 100, 0, 7);
    send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 32768, 32768, 7);
    send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 70000, 70000, 7);
    send_tri(0, 0, 0, 3, 0, 1, 0, 3, 0, 1, 1, 0);
    send_tri(0, 0, 0, 3, 0, 1, 0, 3, 0, 1, 1, 1);
    send_tri(mn, mn, 0, mx, mn, 0, mn, mx, 0, -5, -5, mx);
    send_tri(mn, mn, 0, mn, mx, 0, mx, mn, 0, -5, -5, mx);
    send_tri(-1, -1, -1, 1, -1, -1, -1, 1, -1, -1, -1, -1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 0;
        default: idle_pct = 11;
      endcase
      for (int n = 0; n < 320; n++) send_random();
      start <= 1'b0;
      while (pending != 0) @(negedge clk);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule
